### hdl/tevq_pkg.sv
// Package for the timed event queue: field widths, operation and status codes,
// and parameter defaults. No dependencies.
`default_nettype none
package tevq_pkg;
   localparam int DEF_QUEUE_DEPTH = 64;
   localparam int DEF_PROC_BITS   = 8;
   localparam int DEF_TIME_BITS   = 48;

   localparam int KIND_W = 2;
   localparam int PID_W  = 8;
   localparam int TIME_W = 48;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 7;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 64;

   localparam logic [KIND_W-1:0] KIND_AT       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELATIVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_W-1:0] ST_ALREADY   = 2'd3;
endpackage
`default_nettype wire

### hdl/tevq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tevq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

### hdl/timed_event_queue.sv
// Timed event queue top level: sorted notice list in one RAM, scan/shift sequencer.
// Depends on tevq_pkg and tevq_ram.
//
//  channel | dir | beat contents
//  req     | in  | tuser kind; tdata proc_id, event_time, ref_proc_id, place_after
//  rsp     | out | tuser status; tdata head_valid, head_proc, head_time, occupancy
//
// One request at a time. Each request other than clear scans the list through the
// single RAM read port; an insert or remove also shifts the notices behind its
// position through that port.
// Reset empties the list at once; no clearing pass.
// A stalled rsp holds the sequencer before it loads the next result.
`default_nettype none
module timed_event_queue #(
   parameter int QUEUE_DEPTH = tevq_pkg::DEF_QUEUE_DEPTH,
   parameter int PROC_BITS   = tevq_pkg::DEF_PROC_BITS,
   parameter int TIME_BITS   = tevq_pkg::DEF_TIME_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [1:0] kind
   input  wire logic [tevq_pkg::KIND_W-1:0]     req_tuser,
   // [7:0] proc_id, [55:8] event_time, [63:56] ref_proc_id, [64] place_after
   input  wire logic [tevq_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [1:0] status
   output logic      [tevq_pkg::STAT_W-1:0]     rsp_tuser,
   // [0] head_valid, [8:1] head_proc, [56:9] head_time, [63:57] occupancy
   output logic      [tevq_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ENT_BITS = PROC_BITS + TIME_BITS;
   localparam int PW = (PROC_BITS > tevq_pkg::PID_W) ? PROC_BITS : tevq_pkg::PID_W;
   localparam int TW = (TIME_BITS > tevq_pkg::TIME_W) ? TIME_BITS : tevq_pkg::TIME_W;
   localparam int CW = (CNT_BITS > tevq_pkg::OCC_W) ? CNT_BITS : tevq_pkg::OCC_W;
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(QUEUE_DEPTH);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN     = 3'd1;
   localparam logic [2:0] S_DECIDE   = 3'd2;
   localparam logic [2:0] S_SHIFT_UP = 3'd3;
   localparam logic [2:0] S_SHIFT_DN = 3'd4;
   localparam logic [2:0] S_PUT      = 3'd5;
   localparam logic [2:0] S_HEAD_RD  = 3'd6;
   localparam logic [2:0] S_HEAD_CAP = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [tevq_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [PROC_BITS-1:0] pid_ff, pid_in, rid_ff, rid_in;
   logic [TIME_BITS-1:0] tm_ff, tm_in;
   logic after_ff, after_in;
   logic [tevq_pkg::STAT_W-1:0] status_ff, status_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic issue_on_ff, issue_on_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic pid_hit_ff, pid_hit_in, rid_hit_ff, rid_hit_in, ins_hit_ff, ins_hit_in;
   logic [CNT_BITS-1:0] pid_pos_ff, pid_pos_in, rid_pos_ff, rid_pos_in;
   logic [CNT_BITS-1:0] ins_pos_ff, ins_pos_in, tgt_pos_ff, tgt_pos_in;
   logic [TIME_BITS-1:0] rid_time_ff, rid_time_in, new_time_ff, new_time_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [tevq_pkg::STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [tevq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic ram_we, ram_re;
   logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
   logic [ENT_BITS-1:0] ram_wdata, ram_rdata;
   logic [PROC_BITS-1:0] rd_proc;
   logic [TIME_BITS-1:0] rd_time;

   logic [PW-1:0] pid_wide, rid_wide, hproc_wide;
   logic [TW-1:0] tm_wide, htime_wide;
   logic [CW-1:0] occ_wide;
   logic issue;

   tevq_ram #(.WIDTH(ENT_BITS), .DEPTH(QUEUE_DEPTH)) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rd_proc = ram_rdata[ENT_BITS-1:TIME_BITS];
   assign rd_time = ram_rdata[TIME_BITS-1:0];

   assign pid_wide = PW'(req_tdata[7:0]);
   assign rid_wide = PW'(req_tdata[63:56]);
   assign tm_wide  = TW'(req_tdata[55:8]);
   assign hproc_wide = PW'(rd_proc);
   assign htime_wide = TW'(rd_time);
   assign occ_wide   = CW'(count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      kind_in     = kind_ff;
      pid_in      = pid_ff;
      rid_in      = rid_ff;
      tm_in       = tm_ff;
      after_in    = after_ff;
      status_in   = status_ff;
      idx_in      = idx_ff;
      issue_on_in = issue_on_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      pid_hit_in  = pid_hit_ff;
      rid_hit_in  = rid_hit_ff;
      ins_hit_in  = ins_hit_ff;
      pid_pos_in  = pid_pos_ff;
      rid_pos_in  = rid_pos_ff;
      ins_pos_in  = ins_pos_ff;
      tgt_pos_in  = tgt_pos_ff;
      rid_time_in = rid_time_ff;
      new_time_in = new_time_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we    = 1'b0;
      ram_waddr = rd_idx_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = idx_ff[IDX_BITS-1:0];
      issue     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in    = req_tuser;
               pid_in     = pid_wide[PROC_BITS-1:0];
               rid_in     = rid_wide[PROC_BITS-1:0];
               tm_in      = tm_wide[TIME_BITS-1:0];
               after_in   = req_tdata[64];
               status_in  = tevq_pkg::ST_OK;
               idx_in     = '0;
               pid_hit_in = 1'b0;
               rid_hit_in = 1'b0;
               ins_hit_in = 1'b0;
               pid_pos_in = count_ff;
               rid_pos_in = count_ff;
               ins_pos_in = count_ff;
               if (req_tuser == tevq_pkg::KIND_CLEAR) begin
                  count_in = '0;
                  state_in = S_HEAD_RD;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            issue = (idx_ff < count_ff);
            if (issue) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[IDX_BITS-1:0];
               rd_idx_in = idx_ff[IDX_BITS-1:0];
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CNT_BITS'(1);
            end
            if (rd_vld_ff) begin
               if (!pid_hit_ff && rd_proc == pid_ff) begin
                  pid_hit_in = 1'b1;
                  pid_pos_in = CNT_BITS'(rd_idx_ff);
               end
               if (!rid_hit_ff && rd_proc == rid_ff) begin
                  rid_hit_in  = 1'b1;
                  rid_pos_in  = CNT_BITS'(rd_idx_ff);
                  rid_time_in = rd_time;
               end
               if (!ins_hit_ff && rd_time >= tm_ff) begin
                  ins_hit_in = 1'b1;
                  ins_pos_in = CNT_BITS'(rd_idx_ff);
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_HEAD_RD;
            priority if (kind_ff == tevq_pkg::KIND_REMOVE) begin
               if (!pid_hit_ff) begin
                  status_in = tevq_pkg::ST_NOT_FOUND;
               end else if (pid_pos_ff + CNT_BITS'(1) < count_ff) begin
                  idx_in      = pid_pos_ff + CNT_BITS'(1);
                  issue_on_in = 1'b1;
                  state_in    = S_SHIFT_DN;
               end else begin
                  count_in = count_ff - CNT_BITS'(1);
               end
            end else if (pid_hit_ff) begin
               status_in = tevq_pkg::ST_ALREADY;
            end else if (kind_ff == tevq_pkg::KIND_RELATIVE && !rid_hit_ff) begin
               status_in = tevq_pkg::ST_NOT_FOUND;
            end else if (count_ff >= FULL_CNT) begin
               status_in = tevq_pkg::ST_FULL;
            end else begin
               if (kind_ff == tevq_pkg::KIND_RELATIVE) begin
                  tgt_pos_in  = rid_pos_ff + CNT_BITS'(after_ff);
                  new_time_in = rid_time_ff;
               end else begin
                  tgt_pos_in  = ins_pos_ff;
                  new_time_in = tm_ff;
               end
               if (tgt_pos_in == count_ff) begin
                  state_in = S_PUT;
               end else begin
                  idx_in      = count_ff - CNT_BITS'(1);
                  issue_on_in = 1'b1;
                  state_in    = S_SHIFT_UP;
               end
            end
         end
         S_SHIFT_UP: begin
            if (issue_on_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[IDX_BITS-1:0];
               rd_idx_in = idx_ff[IDX_BITS-1:0];
               rd_vld_in = 1'b1;
               if (idx_ff == tgt_pos_ff) begin
                  issue_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff - CNT_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff + IDX_BITS'(1);
            end
            if (!issue_on_ff && !rd_vld_ff) begin
               state_in = S_PUT;
            end
         end
         S_SHIFT_DN: begin
            if (issue_on_ff) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[IDX_BITS-1:0];
               rd_idx_in = idx_ff[IDX_BITS-1:0];
               rd_vld_in = 1'b1;
               if (idx_ff == count_ff - CNT_BITS'(1)) begin
                  issue_on_in = 1'b0;
               end else begin
                  idx_in = idx_ff + CNT_BITS'(1);
               end
            end
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = rd_idx_ff - IDX_BITS'(1);
            end
            if (!issue_on_ff && !rd_vld_ff) begin
               count_in = count_ff - CNT_BITS'(1);
               state_in = S_HEAD_RD;
            end
         end
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = tgt_pos_ff[IDX_BITS-1:0];
            ram_wdata = {pid_ff, new_time_ff};
            count_in  = count_ff + CNT_BITS'(1);
            state_in  = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            state_in  = S_HEAD_CAP;
         end
         S_HEAD_CAP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = status_ff;
               if (count_ff != '0) begin
                  rsp_data_in = {occ_wide[tevq_pkg::OCC_W-1:0],
                                 htime_wide[tevq_pkg::TIME_W-1:0],
                                 hproc_wide[tevq_pkg::PID_W-1:0], 1'b1};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_on_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_on_ff  <= issue_on_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      pid_ff      <= pid_in;
      rid_ff      <= rid_in;
      tm_ff       <= tm_in;
      after_ff    <= after_in;
      status_ff   <= status_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= rd_idx_in;
      pid_hit_ff  <= pid_hit_in;
      rid_hit_ff  <= rid_hit_in;
      ins_hit_ff  <= ins_hit_in;
      pid_pos_ff  <= pid_pos_in;
      rid_pos_ff  <= rid_pos_in;
      ins_pos_ff  <= ins_pos_in;
      tgt_pos_ff  <= tgt_pos_in;
      rid_time_ff <= rid_time_in;
      new_time_ff <= new_time_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

### tb/tb_timed_event_queue.sv
// Testbench for timed_event_queue: directed table then bursty random traffic,
// each response checked against fixed expectations or a built-in sorted-list model.
`default_nettype none
module tb_timed_event_queue;
   localparam int DEPTH = tevq_pkg::DEF_QUEUE_DEPTH;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [tevq_pkg::STAT_W-1:0] status;
      logic                        head_valid;
      logic [tevq_pkg::PID_W-1:0]  head_proc;
      logic [tevq_pkg::TIME_W-1:0] head_time;
      logic [tevq_pkg::OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct {
      logic [tevq_pkg::KIND_W-1:0] kind;
      logic [tevq_pkg::PID_W-1:0]  pid;
      logic [tevq_pkg::TIME_W-1:0] tm;
      logic [tevq_pkg::PID_W-1:0]  rid;
      logic                        after;
      logic                        has_exp;
      rsp_type                     exp;
   } step_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [tevq_pkg::KIND_W-1:0] req_tuser = '0;
   logic [tevq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [tevq_pkg::STAT_W-1:0] rsp_tuser;
   logic [tevq_pkg::RSP_DATA_W-1:0] rsp_tdata;

   timed_event_queue DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // notice list model
   logic [tevq_pkg::PID_W-1:0]  list_pid[DEPTH];
   logic [tevq_pkg::TIME_W-1:0] list_tm[DEPTH];
   int                          list_len;

   rsp_type head_q[$];
   step_type stim_q[$];
   int errors = 0;
   int checked = 0;
   int cycles = 0;
   bit long_hold = 0;
   bit stim_done = 0;
   int full_hits = 0;

   function automatic int locate(logic [tevq_pkg::PID_W-1:0] p);
      for (int i = 0; i < list_len; i++) if (list_pid[i] == p) return i;
      return list_len;
   endfunction

   function automatic void insert_at(int pos, logic [tevq_pkg::PID_W-1:0] p,
                                     logic [tevq_pkg::TIME_W-1:0] t);
      for (int i = list_len; i > pos; i--) begin
         list_pid[i] = list_pid[i-1];
         list_tm[i] = list_tm[i-1];
      end
      list_pid[pos] = p;
      list_tm[pos] = t;
      list_len++;
   endfunction

   function automatic rsp_type apply_op(step_type s);
      rsp_type r;
      int pos, rpos;
      r.status = tevq_pkg::ST_OK;
      case (s.kind)
         tevq_pkg::KIND_AT: begin
            if (locate(s.pid) < list_len) r.status = tevq_pkg::ST_ALREADY;
            else if (list_len >= DEPTH) r.status = tevq_pkg::ST_FULL;
            else begin
               pos = 0;
               while (pos < list_len && list_tm[pos] < s.tm) pos++;
               insert_at(pos, s.pid, s.tm);
            end
         end
         tevq_pkg::KIND_RELATIVE: begin
            rpos = locate(s.rid);
            if (locate(s.pid) < list_len) r.status = tevq_pkg::ST_ALREADY;
            else if (rpos >= list_len) r.status = tevq_pkg::ST_NOT_FOUND;
            else if (list_len >= DEPTH) r.status = tevq_pkg::ST_FULL;
            else insert_at(s.after ? rpos + 1 : rpos, s.pid, list_tm[rpos]);
         end
         tevq_pkg::KIND_REMOVE: begin
            pos = locate(s.pid);
            if (pos >= list_len) r.status = tevq_pkg::ST_NOT_FOUND;
            else begin
               for (int i = pos; i + 1 < list_len; i++) begin
                  list_pid[i] = list_pid[i+1];
                  list_tm[i] = list_tm[i+1];
               end
               list_len--;
            end
         end
         default: list_len = 0;
      endcase
      if (r.status == tevq_pkg::ST_FULL) full_hits++;
      r.head_valid = list_len > 0;
      r.head_proc = list_len > 0 ? list_pid[0] : '0;
      r.head_time = list_len > 0 ? list_tm[0] : '0;
      r.occupancy = tevq_pkg::OCC_W'(list_len);
      return r;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h (beat %0d)", what, got, want, checked);
   endtask

   function automatic step_type mk(logic [tevq_pkg::KIND_W-1:0] k,
                                   logic [tevq_pkg::PID_W-1:0] p,
                                   logic [tevq_pkg::TIME_W-1:0] t,
                                   logic [tevq_pkg::PID_W-1:0] rr,
                                   logic a);
      step_type s;
      s.kind = k; s.pid = p; s.tm = t; s.rid = rr; s.after = a;
      s.has_exp = 0; s.exp = '0;
      return s;
   endfunction

   function automatic step_type mk_exp(step_type s, logic [tevq_pkg::STAT_W-1:0] st,
                                       logic hv, logic [tevq_pkg::PID_W-1:0] hp,
                                       logic [tevq_pkg::TIME_W-1:0] ht,
                                       logic [tevq_pkg::OCC_W-1:0] oc);
      s.has_exp = 1;
      s.exp = '{st, hv, hp, ht, oc};
      return s;
   endfunction

   // random pid from a small pool so hits and misses both occur
   function automatic logic [tevq_pkg::PID_W-1:0] pick_pid();
      if ($urandom_range(0, 9) == 0) return tevq_pkg::PID_W'($urandom);
      return tevq_pkg::PID_W'($urandom_range(0, 79));
   endfunction

   function automatic logic [tevq_pkg::TIME_W-1:0] pick_tm();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return tevq_pkg::TIME_W'($urandom_range(0, 7));
         default: return {$urandom, 16'($urandom)};
      endcase
   endfunction

   // build stimulus
   initial begin
      step_type s;
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_REMOVE, 8'd5, '0, 8'd0, 0),
                              tevq_pkg::ST_NOT_FOUND, 0, 0, 0, 0));
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_RELATIVE, 8'd1, '0, 8'd2, 1),
                              tevq_pkg::ST_NOT_FOUND, 0, 0, 0, 0));
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_CLEAR, 8'hff, '1, 8'hff, 1),
                              tevq_pkg::ST_OK, 0, 0, 0, 0));
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_AT, 8'hff, '1, 8'h00, 0),
                              tevq_pkg::ST_OK, 1, 8'hff, '1, 1));
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_AT, 8'h00, '0, 8'hff, 1),
                              tevq_pkg::ST_OK, 1, 8'h00, '0, 2));
      stim_q.push_back(mk_exp(mk(tevq_pkg::KIND_AT, 8'h00, 48'd5, 8'h00, 0),
                              tevq_pkg::ST_ALREADY, 1, 8'h00, '0, 2));
      stim_q.push_back(mk(tevq_pkg::KIND_AT, 8'd7, '0, 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd8, '0, 8'd7, 1));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd9, '1, 8'hff, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd10, '0, 8'hff, 1));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd7, '0, 8'd7, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd11, '0, 8'd11, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_REMOVE, 8'd7, '0, 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_REMOVE, 8'h00, '0, 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_AT, 8'h55, 48'haaaa_aaaa_aaaa, 8'haa, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_AT, 8'haa, 48'h5555_5555_5555, 8'h55, 1));
      // fill to capacity, then the full cases
      for (int i = 0; i < DEPTH; i++)
         stim_q.push_back(mk(tevq_pkg::KIND_AT, tevq_pkg::PID_W'(100 + i),
                             tevq_pkg::TIME_W'(i % 5), 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_AT, 8'd3, 48'd2, 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd3, '0, 8'd100, 1));
      stim_q.push_back(mk(tevq_pkg::KIND_RELATIVE, 8'd3, '0, 8'd4, 1));
      stim_q.push_back(mk(tevq_pkg::KIND_REMOVE, 8'd130, '0, 8'd0, 0));
      stim_q.push_back(mk(tevq_pkg::KIND_CLEAR, '0, '0, '0, 0));
      // random: mostly inserts, with removes and clears
      for (int i = 0; i < 600; i++) begin
         int r;
         r = $urandom_range(0, 99);
         s = mk(tevq_pkg::KIND_AT, pick_pid(), pick_tm(), pick_pid(), 1'($urandom));
         s.tm = $urandom_range(0, 3) == 0 ? s.tm : {$urandom, 16'($urandom)};
         if (r < 40) s.kind = tevq_pkg::KIND_AT;
         else if (r < 70) s.kind = tevq_pkg::KIND_RELATIVE;
         else if (r < 97) s.kind = tevq_pkg::KIND_REMOVE;
         else s.kind = tevq_pkg::KIND_CLEAR;
         stim_q.push_back(s);
      end
   end

   // sender: bursts and gaps
   initial begin
      step_type s;
      int burst, gap;
      repeat (10) @(posedge clock);
      @(negedge clock) reset = 0;
      while (stim_q.size() > 0) begin
         burst = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         for (int b = 0; b < burst && stim_q.size() > 0; b++) begin
            s = stim_q.pop_front();
            req_tuser = s.kind;
            req_tdata = {7'b0, s.after, s.rid, s.tm, s.pid};
            req_tvalid = 1;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            head_q.push_back(s.has_exp ? s.exp : apply_op(s));
            if (s.has_exp) void'(apply_op(s));
            @(negedge clock);
         end
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 0;
      stim_done = 1;
   end

   // receiver: own stall pattern, one long hold-off early on
   initial begin
      int hold;
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         if (!long_hold && checked == 30) begin
            long_hold = 1;
            rsp_tready = 0;
            for (hold = 0; hold < 400; hold++) @(negedge clock);
         end
         rsp_tready = (cycles % 23) < 15 ? 1'b1 : 1'($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[0], rsp_tdata[8:1], rsp_tdata[56:9],
                 rsp_tdata[63:57]};
         checked <= checked + 1;
         if (head_q.size() == 0) report("unexpected beat", rsp_tdata, 0);
         else begin
            want = head_q.pop_front();
            if (got.status != want.status) report("status", got.status, want.status);
            if (got.head_valid != want.head_valid)
               report("head_valid", got.head_valid, want.head_valid);
            if (got.head_proc != want.head_proc)
               report("head_proc", got.head_proc, want.head_proc);
            if (got.head_time != want.head_time)
               report("head_time", got.head_time, want.head_time);
            if (got.occupancy != want.occupancy)
               report("occupancy", got.occupancy, want.occupancy);
         end
      end
   end

   initial begin
      wait (stim_done && head_q.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d responses, %0d full-list rejections, long rsp stall applied",
               checked, full_hits);
      if (errors == 0 && head_q.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
hdl/tevq_pkg.sv
hdl/tevq_ram.sv
hdl/timed_event_queue.sv
tb/tb_timed_event_queue.sv
